// ===== design/detection_cluster_plot_extractor_top_assert.svh =====
// Assertion macros used by the port-level checker of the plot extractor.
`ifndef DETECTION_CLUSTER_PLOT_EXTRACTOR_TOP_ASSERT_SVH
`define DETECTION_CLUSTER_PLOT_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DCPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dcpe assertion failed");

// Next-cycle implication.
`define DCPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dcpe assertion failed");

`endif

// ===== design/dcpe_pkg.sv =====
// Types, constants and the slot judge function of the plot extractor.
package dcpe_pkg;

  localparam int Slots   = 16;
  localparam int Cells   = 256;
  localparam int MaxHits = 64;
  localparam int LeftW   = $clog2(Slots + 1);
  localparam int HitW    = $clog2(MaxHits + 1);

  localparam logic [15:0] Turn   = 16'd6000;
  localparam logic [7:0]  AgeMax = 8'd255;

  localparam logic [2:0] RegFind    = 3'd0;
  localparam logic [2:0] RegUpdDist = 3'd1;
  localparam logic [2:0] RegRwMin   = 3'd2;
  localparam logic [2:0] RegRwMax   = 3'd3;
  localparam logic [2:0] RegPwMin   = 3'd4;
  localparam logic [2:0] RegPwMax   = 3'd5;
  localparam logic [2:0] RegAgeLim  = 3'd6;

  typedef struct packed {
    logic        active;
    logic [7:0]  rs;
    logic [7:0]  re;
    logic [12:0] ps;
    logic [12:0] pe;
    logic [7:0]  age;
  } slot_t;

  typedef struct packed {
    logic [7:0]  find_value;
    logic [7:0]  update_distance;
    logic [7:0]  range_width_min;
    logic [7:0]  range_width_max;
    logic [12:0] phase_width_min;
    logic [12:0] phase_width_max;
    logic [7:0]  age_limit;
  } cfg_t;

  typedef struct packed {
    logic        age_en;
    logic        hit_en;
    logic        shift;
    logic [7:0]  idx;
    logic [12:0] az;
  } cell_ctl_t;

  typedef struct packed {
    logic matched;
    logic free_seen;
  } chain_t;

  typedef struct packed {
    logic        close;
    logic        emit;
    logic [7:0]  rc;
    logic [12:0] pc;
  } judge_t;

  function automatic judge_t judge(slot_t s, cfg_t c);
    judge_t      j;
    logic [7:0]  rw;
    logic [15:0] pw;
    logic [15:0] pc;
    rw = s.re - s.rs;
    if (s.pe > s.ps) begin
      pw = {3'b000, s.pe} - {3'b000, s.ps};
    end else begin
      pw = {3'b000, s.pe} + Turn - {3'b000, s.ps};
    end
    j.close = s.active && (s.age >= c.age_limit);
    // a negative wrapped width means a huge unsigned width: reject
    j.emit = j.close && (rw >= c.range_width_min) && (rw <= c.range_width_max) &&
             !pw[15] && (pw >= {3'b000, c.phase_width_min}) &&
             (pw <= {3'b000, c.phase_width_max});
    pc = {3'b000, s.ps} + {1'b0, pw[15:1]};
    if (pc > Turn) begin
      pc = pc - Turn;
    end
    j.pc = pc[12:0];
    j.rc = s.rs + {1'b0, rw[7:1]};
    return j;
  endfunction

endpackage

// ===== design/dcpe_cell.sv =====
// One cluster slot: join or open on a hit, age per sweep, shift during the close scan.
module dcpe_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcpe_pkg::cell_ctl_t ctl_i,
  input  dcpe_pkg::cfg_t     cfg_i,
  input  dcpe_pkg::slot_t    shift_in_i,
  input  dcpe_pkg::chain_t   chain_i,
  input  logic               any_match_i,
  output dcpe_pkg::slot_t    slot_o,
  output dcpe_pkg::chain_t   chain_o,
  output dcpe_pkg::judge_t   judge_o
);

  dcpe_pkg::slot_t slot_q, slot_d;
  logic [7:0] dist_end, dist_start;
  logic       match_me, free_me;

  assign dist_end   = (ctl_i.idx >= slot_q.re) ? ctl_i.idx - slot_q.re : slot_q.re - ctl_i.idx;
  assign dist_start = (ctl_i.idx >= slot_q.rs) ? ctl_i.idx - slot_q.rs : slot_q.rs - ctl_i.idx;
  assign match_me   = ctl_i.hit_en && slot_q.active &&
                      ((dist_end < cfg_i.update_distance) ||
                       (dist_start < cfg_i.update_distance));
  assign free_me    = !slot_q.active;

  assign chain_o.matched   = chain_i.matched | match_me;
  assign chain_o.free_seen = chain_i.free_seen | free_me;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.shift) begin
      slot_d = shift_in_i;
    end else begin
      if (ctl_i.age_en && slot_q.active && slot_q.age != dcpe_pkg::AgeMax) begin
        slot_d.age = slot_q.age + 8'd1;
      end
      if (match_me && !chain_i.matched) begin
        if (ctl_i.idx < slot_q.rs) slot_d.rs = ctl_i.idx;
        if (ctl_i.idx > slot_q.re) slot_d.re = ctl_i.idx;
        slot_d.pe  = ctl_i.az;
        slot_d.age = '0;
      end
      // open only the lowest free slot, and only when nobody joined
      if (ctl_i.hit_en && !any_match_i && free_me && !chain_i.free_seen) begin
        slot_d.active = 1'b1;
        slot_d.rs     = ctl_i.idx;
        slot_d.re     = ctl_i.idx;
        slot_d.ps     = ctl_i.az;
        slot_d.pe     = ctl_i.az;
        slot_d.age    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o  = slot_q;
  assign judge_o = dcpe_pkg::judge(slot_q, cfg_i);

endmodule

// ===== design/detection_cluster_plot_extractor_top.sv =====
// Top level of the detection cluster plot extractor: slot chain, scan control, APB registers.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata cell fields, tuser first, tlast last of sweep
//   m_axis    out  tvalid/tready        tdata range/phase center, tlast last plot
//   apb       in   psel/penable/pready  7 registers at 4*i
//
// A cell without end of sweep leaves intake open for the next cell. A cell marked last of
// sweep starts a scan that rotates all Slots (16) slots once through the head cell; a shift
// is held back while a plot still waiting on m_axis_tready blocks the next emitting slot.
// No cell is accepted during the scan.
// Reset is asynchronous and clears every slot and the registers to their defaults.
module detection_cluster_plot_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // cell_value[7:0], cell_index[15:8], azimuth[28:16]
  input  logic        s_axis_tuser,  // first_of_sweep
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // range_center[7:0], phase_center[20:8]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StScan = 1'b1;

  dcpe_pkg::cfg_t      cfg_q;
  dcpe_pkg::cell_ctl_t ctl;
  dcpe_pkg::slot_t     slots   [dcpe_pkg::Slots];
  dcpe_pkg::slot_t     shift_in[dcpe_pkg::Slots];
  dcpe_pkg::judge_t    judges  [dcpe_pkg::Slots];
  dcpe_pkg::chain_t    chain   [dcpe_pkg::Slots + 1];

  logic [0:0] state_q, state_d;
  logic [dcpe_pkg::LeftW-1:0] left_q, left_d;
  logic [dcpe_pkg::HitW-1:0]  hits_q, hits_d, hits_base;
  logic        accept, hit, out_free, step, later_emit;
  logic        m_valid_q, m_valid_d, m_last_q, m_last_d;
  logic [23:0] m_data_q, m_data_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.find_value      <= 8'd0;
      cfg_q.update_distance <= 8'd2;
      cfg_q.range_width_min <= 8'd0;
      cfg_q.range_width_max <= 8'd2;
      cfg_q.phase_width_min <= 13'd30;
      cfg_q.phase_width_max <= 13'd500;
      cfg_q.age_limit       <= 8'd10;
    end else if (wr_en) begin
      case (paddr[4:2])
        dcpe_pkg::RegFind:    cfg_q.find_value      <= pwdata[7:0];
        dcpe_pkg::RegUpdDist: cfg_q.update_distance <= pwdata[7:0];
        dcpe_pkg::RegRwMin:   cfg_q.range_width_min <= pwdata[7:0];
        dcpe_pkg::RegRwMax:   cfg_q.range_width_max <= pwdata[7:0];
        dcpe_pkg::RegPwMin:   cfg_q.phase_width_min <= pwdata[12:0];
        dcpe_pkg::RegPwMax:   cfg_q.phase_width_max <= pwdata[12:0];
        dcpe_pkg::RegAgeLim:  cfg_q.age_limit       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      dcpe_pkg::RegFind:    prdata = {24'd0, cfg_q.find_value};
      dcpe_pkg::RegUpdDist: prdata = {24'd0, cfg_q.update_distance};
      dcpe_pkg::RegRwMin:   prdata = {24'd0, cfg_q.range_width_min};
      dcpe_pkg::RegRwMax:   prdata = {24'd0, cfg_q.range_width_max};
      dcpe_pkg::RegPwMin:   prdata = {19'd0, cfg_q.phase_width_min};
      dcpe_pkg::RegPwMax:   prdata = {19'd0, cfg_q.phase_width_max};
      dcpe_pkg::RegAgeLim:  prdata = {24'd0, cfg_q.age_limit};
      default:              prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hits_base     = s_axis_tuser ? '0 : hits_q;
  assign hit = accept && (s_axis_tdata[7:0] == cfg_q.find_value) &&
               (int'(s_axis_tdata[15:8]) < dcpe_pkg::Cells) &&
               (int'(hits_base) < dcpe_pkg::MaxHits);
  assign hits_d = accept ? (hit ? hits_base + 1'b1 : hits_base) : hits_q;

  assign out_free = !m_valid_q || m_axis_tready;
  assign step     = (state_q == StScan) && (!judges[0].emit || out_free);

  assign ctl.age_en = accept && s_axis_tuser;
  assign ctl.hit_en = hit;
  assign ctl.shift  = step;
  assign ctl.idx    = s_axis_tdata[15:8];
  assign ctl.az     = s_axis_tdata[28:16];

  assign chain[0] = '0;

  for (genvar i = 0; i < dcpe_pkg::Slots; i++) begin : g_cell
    if (i == dcpe_pkg::Slots - 1) begin : g_tail
      // the head slot wraps to the tail, cleared if it closed
      assign shift_in[i] = judges[0].close ? '0 : slots[0];
    end else begin : g_mid
      assign shift_in[i] = slots[i+1];
    end
    dcpe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cfg_i       (cfg_q),
      .shift_in_i  (shift_in[i]),
      .chain_i     (chain[i]),
      .any_match_i (chain[dcpe_pkg::Slots].matched),
      .slot_o      (slots[i]),
      .chain_o     (chain[i+1]),
      .judge_o     (judges[i])
    );
  end

  // any emitting slot still ahead of the head in this scan
  always_comb begin
    later_emit = 1'b0;
    for (int i = 1; i < dcpe_pkg::Slots; i++) begin
      if (i < int'(left_q) && judges[i].emit) later_emit = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    left_d    = left_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    if (m_axis_tready) m_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept && s_axis_tlast) begin
          state_d = StScan;
          left_d  = dcpe_pkg::LeftW'(dcpe_pkg::Slots);
        end
      end
      StScan: begin
        if (step) begin
          left_d = left_q - 1'b1;
          if (left_q == dcpe_pkg::LeftW'(1)) state_d = StIdle;
          if (judges[0].emit) begin
            m_valid_d = 1'b1;
            m_data_d  = {3'b000, judges[0].pc, judges[0].rc};
            m_last_d  = !later_emit;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      left_q    <= '0;
      hits_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      left_q    <= left_d;
      hits_q    <= hits_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== design/dcpe_checker.sv =====
// Port-level checker for the plot extractor, bound to the top level.
`include "detection_cluster_plot_extractor_top_assert.svh"

module dcpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        pready
);

  // an end-of-sweep item starts the scan, so intake closes at once
  `DCPE_ASSERT_NEXT(a_scan_blocks, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  // hold a stalled plot
  `DCPE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `DCPE_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind detection_cluster_plot_extractor_top dcpe_checker u_dcpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

// ===== verif/plot_checker.sv =====
// Checker for the plot extractor: watches both streams, predicts plots and compares.
`timescale 1ns / 100ps
module plot_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          plots_pending
);

  typedef struct packed {
    logic [7:0]  rc;
    logic [12:0] pc;
    logic        last;
  } plot_t;

  plot_t            plot_queue[$];
  dcpe_pkg::cfg_t   regs;
  dcpe_pkg::slot_t  slots[dcpe_pkg::Slots];
  int               hit_count;

  function automatic int unsigned gap(int unsigned a, int unsigned b);
    return a >= b ? a - b : b - a;
  endfunction

  task automatic add_hit(int unsigned idx, logic [12:0] az);
    int free_slot;
    free_slot = -1;
    for (int s = 0; s < dcpe_pkg::Slots; s++) begin
      if (slots[s].active) begin
        if (gap(idx, 32'(slots[s].re)) < regs.update_distance ||
            gap(idx, 32'(slots[s].rs)) < regs.update_distance) begin
          if (idx < slots[s].rs) slots[s].rs = 8'(idx);
          if (idx > slots[s].re) slots[s].re = 8'(idx);
          slots[s].pe = az;
          slots[s].age = 8'd0;
          return;
        end
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (free_slot >= 0) begin
      slots[free_slot] = '{active: 1'b1, rs: 8'(idx), re: 8'(idx), ps: az, pe: az, age: 8'd0};
    end
  endtask

  task automatic take_cell(logic [31:0] data, logic first, logic last);
    int unsigned val, idx, rw, pw, pc;
    logic [12:0] az;
    plot_t       p;
    int          n;
    val = 32'(data[7:0]);
    idx = 32'(data[15:8]);
    az = data[28:16];
    n = 0;
    if (first) begin
      for (int s = 0; s < dcpe_pkg::Slots; s++)
        if (slots[s].active && slots[s].age < 255) slots[s].age++;
      hit_count = 0;
    end
    if (val == regs.find_value && idx < dcpe_pkg::Cells && hit_count < dcpe_pkg::MaxHits) begin
      hit_count++;
      add_hit(idx, az);
    end
    if (last) begin
      for (int s = 0; s < dcpe_pkg::Slots; s++) begin
        if (!slots[s].active || slots[s].age < regs.age_limit) continue;
        rw = 32'(slots[s].re) - 32'(slots[s].rs);
        if (slots[s].pe > slots[s].ps) pw = 32'(slots[s].pe) - 32'(slots[s].ps);
        else pw = 32'(slots[s].pe) + 6000 - 32'(slots[s].ps);
        if (rw >= regs.range_width_min && rw <= regs.range_width_max &&
            pw >= regs.phase_width_min && pw <= regs.phase_width_max) begin
          pc = 32'(slots[s].ps) + (pw >> 1);
          if (pc > 6000) pc -= 6000;
          p.rc = 8'(32'(slots[s].rs) + (rw >> 1));
          p.pc = pc[12:0];
          p.last = 1'b0;
          plot_queue.push_back(p);
          n++;
        end
        slots[s] = '0;
      end
      if (n > 0) plot_queue[plot_queue.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plot_t want;
    if (!rst_ni) begin
      regs <= '{8'd0, 8'd2, 8'd0, 8'd2, 13'd30, 13'd500, 8'd10};
      for (int s = 0; s < dcpe_pkg::Slots; s++) slots[s] = '0;
      hit_count = 0;
      fail_count = 0;
      plot_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          dcpe_pkg::RegFind:    regs.find_value      <= pwdata[7:0];
          dcpe_pkg::RegUpdDist: regs.update_distance <= pwdata[7:0];
          dcpe_pkg::RegRwMin:   regs.range_width_min <= pwdata[7:0];
          dcpe_pkg::RegRwMax:   regs.range_width_max <= pwdata[7:0];
          dcpe_pkg::RegPwMin:   regs.phase_width_min <= pwdata[12:0];
          dcpe_pkg::RegPwMax:   regs.phase_width_max <= pwdata[12:0];
          dcpe_pkg::RegAgeLim:  regs.age_limit       <= pwdata[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_cell(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (plot_queue.size() == 0) begin
          $error("unexpected plot %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = plot_queue.pop_front();
          if (m_axis_tdata[7:0] !== want.rc) begin
            $error("range_center expected %0d actual %0d", want.rc, m_axis_tdata[7:0]);
            fail_count++;
          end
          if (m_axis_tdata[20:8] !== want.pc) begin
            $error("phase_center expected %0d actual %0d", want.pc, m_axis_tdata[20:8]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_plot expected %0d actual %0d", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
    plots_pending = plot_queue.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Stimulus and verdict for the plot extractor; checking lives in plot_checker.
`timescale 1ns / 100ps
module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0, s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0, s_axis_tlast = 1'b0;
  logic        m_axis_tvalid, m_axis_tready = 1'b0, m_axis_tlast;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int          fail_count, plots_pending;
  bit          calm = 1'b0;
  int          sink_hold = 0;

  always #10 clk_i = ~clk_i;

  detection_cluster_plot_extractor_top dut (.*);

  plot_checker checker_i (.*);

  // Random stalls on the plot side, none in the calm stretch.
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_hold <= $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {index, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (plots_pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Leaves tvalid high on return; the next caller drops or reloads it.
  task automatic send_cell(logic [7:0] val, logic [7:0] idx, logic [12:0] az,
                           logic first, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, az, idx, val};
    s_axis_tuser <= first;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One sweep: mostly hits around a few clusters, some noise cells.
  task automatic sweep(logic [7:0] fv, logic [12:0] az, int cells);
    logic [7:0] v;
    for (int c = 0; c < cells; c++) begin
      v = ($urandom_range(0, 3) != 0) ? fv : 8'($urandom);
      send_cell(v, 8'($urandom_range(0, 3) * 60 + $urandom_range(0, 6)), az,
                c == 0, c == cells - 1);
    end
  endtask

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [7:0]  fv;
    logic [12:0] az;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed: wrap, equal ends, extremes of fields, more clusters than slots.
    write_reg(dcpe_pkg::RegAgeLim, 32'd0);
    write_reg(dcpe_pkg::RegPwMin, 32'd0);
    write_reg(dcpe_pkg::RegPwMax, 32'd6000);
    send_cell(8'd0, 8'd255, 13'd5999, 1'b1, 1'b0);
    send_cell(8'd0, 8'd0, 13'd5999, 1'b0, 1'b0);
    send_cell(8'd0, 8'd1, 13'd100, 1'b0, 1'b1);
    send_cell(8'hff, 8'd10, 13'd8191, 1'b1, 1'b1);
    for (int i = 0; i < 18; i++) send_cell(8'd0, 8'(i * 9), 13'(i * 300), i == 0, i == 17);
    drain();
    write_reg(dcpe_pkg::RegFind, 32'd255);
    write_reg(dcpe_pkg::RegUpdDist, 32'd0);
    write_reg(dcpe_pkg::RegRwMin, 32'd255);
    write_reg(dcpe_pkg::RegRwMax, 32'd255);
    send_cell(8'd255, 8'd3, 13'd7, 1'b1, 1'b1);
    drain();
    // Random phases with varied settings.
    for (int ph = 0; ph < 6; ph++) begin
      fv = 8'($urandom);
      write_reg(dcpe_pkg::RegFind, 32'(fv));
      write_reg(dcpe_pkg::RegUpdDist, ph == 5 ? 255 : $urandom_range(1, 8));
      write_reg(dcpe_pkg::RegRwMin, $urandom_range(0, 2));
      write_reg(dcpe_pkg::RegRwMax, ph == 0 ? 255 : $urandom_range(2, 20));
      write_reg(dcpe_pkg::RegPwMin, ph == 0 ? 0 : $urandom_range(0, 200));
      write_reg(dcpe_pkg::RegPwMax, ph == 1 ? 6000 : $urandom_range(300, 6000));
      write_reg(dcpe_pkg::RegAgeLim, ph == 2 ? 255 : $urandom_range(1, 3));
      if (ph == 5) calm = 1'b1;
      az = 13'($urandom_range(0, 5999));
      for (int s = 0; s < 4; s++) begin
        sweep(fv, az, $urandom_range(2, 4));
        az = 13'((az + $urandom_range(0, 400)) % 6000);
      end
      if (ph == 2) drain();
      for (int s = 0; s < 3; s++) send_cell(8'(~fv), 8'($urandom), 13'($urandom), s == 0, 1'b1);
      drain();
    end
    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/dcpe_pkg.sv
design/dcpe_cell.sv
design/detection_cluster_plot_extractor_top.sv
design/dcpe_checker.sv
verif/plot_checker.sv
verif/testbench.sv
